[design/clock_source_divider_search_core_defines.svh]
// Assertion macros for the checker of the divider search core.
`ifndef CLOCK_SOURCE_DIVIDER_SEARCH_CORE_DEFINES_SVH
`define CLOCK_SOURCE_DIVIDER_SEARCH_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSDS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/csds_pkg.sv]
// Types, constants and codes shared by the divider search core modules.
package csds_pkg;

   localparam int SOURCE_COUNT      = 4;
   localparam int MAX_EXPONENT_BITS = 2;
   localparam int MAX_LINEAR_BITS   = 4;

   localparam int RATE_W = 32;
   localparam int SEL_W  = 2;
   localparam int EXP_W  = MAX_EXPONENT_BITS;
   localparam int LIN_W  = MAX_LINEAR_BITS;
   localparam int DIV_W  = MAX_LINEAR_BITS + 1;

   localparam int DIV_BITS_PER_CYCLE = 8;
   localparam int DIV_CYCLES         = RATE_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

   localparam int CSR_INDEX_W = 3;

   localparam int SELECT_FIELD_LSB   = 24;
   localparam int EXPONENT_FIELD_LSB = 8;

   localparam logic [RATE_W-1:0] DEFAULT_SOURCE_RATE = 32'd24000000;
   localparam logic [3:0]        DEFAULT_VALID_MASK  = 4'd1;
   localparam logic [1:0]        DEFAULT_SEL_WIDTH   = 2'd2;
   localparam logic [1:0]        DEFAULT_EXP_WIDTH   = 2'd2;
   localparam logic [2:0]        DEFAULT_LIN_WIDTH   = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_RATE_ZERO  = 3'd0,
      CSR_SOURCE_RATE_ONE   = 3'd1,
      CSR_SOURCE_RATE_TWO   = 3'd2,
      CSR_SOURCE_RATE_THREE = 3'd3,
      CSR_SELECT_VALID_MASK = 3'd4,
      CSR_SELECT_WIDTH      = 3'd5,
      CSR_EXPONENT_WIDTH    = 3'd6,
      CSR_LINEAR_WIDTH      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_FOUND      = 2'd0,
      STATUS_BAD_CONFIG = 2'd1,
      STATUS_NO_RATE    = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic             init;
      logic             load;
      logic             step;
      logic             compare;
      logic             finish;
      logic [SEL_W-1:0] sel;
      logic [EXP_W-1:0] n;
      logic [LIN_W-1:0] m;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             cfg_bad;
      logic             src_ok;
      logic [SEL_W-1:0] sel_max;
      logic [EXP_W-1:0] n_max;
      logic [LIN_W-1:0] m_max;
   } stat_type;

endpackage

[design/clock_source_divider_search_core.sv]
// Top level of the clock source and divider search core.
//
// Usage: configure the eight registers through csr_write_enable, csr_index and
// csr_write_data (one write per clock, no wait). Raise start with
// req_target_rate while busy is low; the transaction is taken at that edge.
// The core tries each allowed source, exponent and linear field in ascending
// order and keeps the first candidate with the smallest error.
// Each candidate passes through a load, four radix-256 division steps of
// the small-divisor divider, and a compare. One transaction is in flight at a
// time; busy is high until the result strobe cycle.
// rsp_valid is high for exactly one cycle, and the result stays on the rsp_ ports
// until the next transaction finishes; the receiver cannot stall it.
// Reset (synchronous) returns the controller to idle, drops rsp_valid and
// loads the register defaults.
module clock_source_divider_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [csds_pkg::RATE_W-1:0]      req_target_rate,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [1:0]                       rsp_best_source,
   output logic [1:0]                       rsp_best_exponent,
   output logic [3:0]                       rsp_best_linear,
   output logic [csds_pkg::RATE_W-1:0]      rsp_achieved_rate,
   output logic [csds_pkg::RATE_W-1:0]      rsp_field_value,
   output logic [csds_pkg::RATE_W-1:0]      rsp_field_mask,
   input  logic                             csr_write_enable,
   input  logic [csds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csds_pkg::RATE_W-1:0]      csr_write_data
);

   csds_pkg::cmd_type  cmd;
   csds_pkg::stat_type stat;

   csds_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   csds_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_target_rate   (req_target_rate),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_best_source   (rsp_best_source),
      .rsp_best_exponent (rsp_best_exponent),
      .rsp_best_linear   (rsp_best_linear),
      .rsp_achieved_rate (rsp_achieved_rate),
      .rsp_field_value   (rsp_field_value),
      .rsp_field_mask    (rsp_field_mask)
   );

endmodule

[design/csds_datapath.sv]
// Datapath: configuration registers, radix-256 divider, best-candidate tracking, result register.
module csds_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [csds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csds_pkg::RATE_W-1:0]    csr_write_data,
   input  logic [csds_pkg::RATE_W-1:0]    req_target_rate,
   input  csds_pkg::cmd_type              cmd,
   output csds_pkg::stat_type             stat,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_best_source,
   output logic [1:0]                     rsp_best_exponent,
   output logic [3:0]                     rsp_best_linear,
   output logic [csds_pkg::RATE_W-1:0]    rsp_achieved_rate,
   output logic [csds_pkg::RATE_W-1:0]    rsp_field_value,
   output logic [csds_pkg::RATE_W-1:0]    rsp_field_mask
);

   // configuration
   logic [csds_pkg::RATE_W-1:0] rate_ff [4];
   logic [3:0]                  mask_ff;
   logic [1:0]                  sel_width_ff;
   logic [1:0]                  exp_width_ff;
   logic [2:0]                  lin_width_ff;

   // saturated widths and field maxima
   logic [1:0]                  sw;
   logic [1:0]                  ew;
   logic [2:0]                  lw;
   logic [csds_pkg::SEL_W-1:0]  sel_max;
   logic [csds_pkg::EXP_W-1:0]  n_max;
   logic [csds_pkg::LIN_W-1:0]  m_max;
   logic [csds_pkg::RATE_W-1:0] source_hz;

   // divider
   logic [csds_pkg::RATE_W-1:0] div_ff;
   logic [csds_pkg::RATE_W-1:0] div_in;
   logic [csds_pkg::DIV_W-1:0]  rem_ff;
   logic [csds_pkg::DIV_W-1:0]  rem_in;
   logic [csds_pkg::DIV_W-1:0]  divisor_ff;
   logic [csds_pkg::DIV_W:0]    trial;

   // search state
   logic [csds_pkg::RATE_W-1:0] target_ff;
   logic [csds_pkg::RATE_W-1:0] delta_ff;
   logic [csds_pkg::RATE_W-1:0] achieved_ff;
   logic [csds_pkg::SEL_W-1:0]  best_sel_ff;
   logic [csds_pkg::EXP_W-1:0]  best_n_ff;
   logic [csds_pkg::LIN_W-1:0]  best_m_ff;
   logic [csds_pkg::RATE_W-1:0] diff;

   // result register
   logic                        rsp_valid_ff;
   csds_pkg::status_type        rsp_status_ff;
   logic [1:0]                  rsp_best_source_ff;
   logic [1:0]                  rsp_best_exponent_ff;
   logic [3:0]                  rsp_best_linear_ff;
   logic [csds_pkg::RATE_W-1:0] rsp_achieved_rate_ff;
   logic [csds_pkg::RATE_W-1:0] rsp_field_value_ff;
   logic [csds_pkg::RATE_W-1:0] rsp_field_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff[0]   <= csds_pkg::DEFAULT_SOURCE_RATE;
         rate_ff[1]   <= '0;
         rate_ff[2]   <= '0;
         rate_ff[3]   <= '0;
         mask_ff      <= csds_pkg::DEFAULT_VALID_MASK;
         sel_width_ff <= csds_pkg::DEFAULT_SEL_WIDTH;
         exp_width_ff <= csds_pkg::DEFAULT_EXP_WIDTH;
         lin_width_ff <= csds_pkg::DEFAULT_LIN_WIDTH;
      end else if (csr_write_enable) begin
         unique case (csds_pkg::csr_index_type'(csr_index))
            csds_pkg::CSR_SOURCE_RATE_ZERO:  rate_ff[0]   <= csr_write_data;
            csds_pkg::CSR_SOURCE_RATE_ONE:   rate_ff[1]   <= csr_write_data;
            csds_pkg::CSR_SOURCE_RATE_TWO:   rate_ff[2]   <= csr_write_data;
            csds_pkg::CSR_SOURCE_RATE_THREE: rate_ff[3]   <= csr_write_data;
            csds_pkg::CSR_SELECT_VALID_MASK: mask_ff      <= csr_write_data[3:0];
            csds_pkg::CSR_SELECT_WIDTH:      sel_width_ff <= csr_write_data[1:0];
            csds_pkg::CSR_EXPONENT_WIDTH:    exp_width_ff <= csr_write_data[1:0];
            csds_pkg::CSR_LINEAR_WIDTH:      lin_width_ff <= csr_write_data[2:0];
         endcase
      end
   end

   always_comb begin
      sw = (sel_width_ff > 2'(csds_pkg::SEL_W)) ? 2'(csds_pkg::SEL_W) : sel_width_ff;
      ew = (exp_width_ff > 2'(csds_pkg::MAX_EXPONENT_BITS)) ?
           2'(csds_pkg::MAX_EXPONENT_BITS) : exp_width_ff;
      lw = (lin_width_ff > 3'(csds_pkg::MAX_LINEAR_BITS)) ?
           3'(csds_pkg::MAX_LINEAR_BITS) : lin_width_ff;
      sel_max = csds_pkg::SEL_W'(((csds_pkg::SEL_W+1)'(1) << sw) - (csds_pkg::SEL_W+1)'(1));
      n_max   = csds_pkg::EXP_W'(((csds_pkg::EXP_W+1)'(1) << ew) - (csds_pkg::EXP_W+1)'(1));
      m_max   = csds_pkg::LIN_W'(((csds_pkg::LIN_W+1)'(1) << lw) - (csds_pkg::LIN_W+1)'(1));
      source_hz = rate_ff[cmd.sel];
   end

   assign stat.cfg_bad = (sw == 2'd0) || (mask_ff == 4'd0) || ((ew == 2'd0) && (lw == 3'd0));
   assign stat.src_ok  = mask_ff[cmd.sel] && (32'(cmd.sel) < 32'(csds_pkg::SOURCE_COUNT))
                         && (source_hz != '0);
   assign stat.sel_max = sel_max;
   assign stat.n_max   = n_max;
   assign stat.m_max   = m_max;

   // restoring division, a byte of quotient per cycle; the divisor is at most
   // 2^LIN_W so the partial remainder stays narrow
   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      trial  = '0;
      for (int i = 0; i < csds_pkg::DIV_BITS_PER_CYCLE; i++) begin
         trial  = {rem_in, div_in[csds_pkg::RATE_W-1]};
         div_in = {div_in[csds_pkg::RATE_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial     = trial - {1'b0, divisor_ff};
            div_in[0] = 1'b1;
         end
         rem_in = trial[csds_pkg::DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_ff     <= source_hz >> cmd.n;
         divisor_ff <= csds_pkg::DIV_W'(cmd.m) + csds_pkg::DIV_W'(1);
         rem_ff     <= '0;
      end else if (cmd.step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   // after the last step div_ff holds the candidate rate
   assign diff = (div_ff > target_ff) ? (div_ff - target_ff) : (target_ff - div_ff);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         target_ff   <= req_target_rate;
         delta_ff    <= req_target_rate;
         achieved_ff <= '0;
         best_sel_ff <= '0;
         best_n_ff   <= '0;
         best_m_ff   <= '0;
      end else if (cmd.compare && (diff < delta_ff)) begin
         delta_ff    <= diff;
         achieved_ff <= div_ff;
         best_sel_ff <= cmd.sel;
         best_n_ff   <= cmd.n;
         best_m_ff   <= cmd.m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_best_source_ff   <= '0;
         rsp_best_exponent_ff <= '0;
         rsp_best_linear_ff   <= '0;
         rsp_achieved_rate_ff <= '0;
         rsp_field_value_ff   <= '0;
         rsp_field_mask_ff    <= '0;
         priority if (stat.cfg_bad) begin
            rsp_status_ff <= csds_pkg::STATUS_BAD_CONFIG;
         end else if (delta_ff == target_ff) begin
            rsp_status_ff <= csds_pkg::STATUS_NO_RATE;
         end else begin
            rsp_status_ff        <= csds_pkg::STATUS_FOUND;
            rsp_best_source_ff   <= 2'(best_sel_ff);
            rsp_best_exponent_ff <= 2'(best_n_ff);
            rsp_best_linear_ff   <= 4'(best_m_ff);
            rsp_achieved_rate_ff <= achieved_ff;
            rsp_field_value_ff   <= (32'(best_sel_ff) << csds_pkg::SELECT_FIELD_LSB)
                                  | (32'(best_n_ff) << csds_pkg::EXPONENT_FIELD_LSB)
                                  | 32'(best_m_ff);
            rsp_field_mask_ff    <= (32'(sel_max) << csds_pkg::SELECT_FIELD_LSB)
                                  | (32'(n_max) << csds_pkg::EXPONENT_FIELD_LSB)
                                  | 32'(m_max);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_best_source   = rsp_best_source_ff;
   assign rsp_best_exponent = rsp_best_exponent_ff;
   assign rsp_best_linear   = rsp_best_linear_ff;
   assign rsp_achieved_rate = rsp_achieved_rate_ff;
   assign rsp_field_value   = rsp_field_value_ff;
   assign rsp_field_mask    = rsp_field_mask_ff;

endmodule

[design/csds_controller.sv]
// Controller: walks source, exponent and linear field, sequencing the datapath.
module csds_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  csds_pkg::stat_type stat,
   output csds_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SOURCE,
      ST_LOAD,
      ST_DIVIDE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   state_type                      state_ff;
   logic [csds_pkg::SEL_W-1:0]     sel_ff;
   logic [csds_pkg::EXP_W-1:0]     n_ff;
   logic [csds_pkg::LIN_W-1:0]     m_ff;
   logic [csds_pkg::DIV_CNT_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
         n_ff     <= '0;
         m_ff     <= '0;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_CHECK;
                  sel_ff   <= '0;
                  n_ff     <= '0;
                  m_ff     <= '0;
               end
            end
            ST_CHECK: begin
               state_ff <= stat.cfg_bad ? ST_FINISH : ST_SOURCE;
            end
            ST_SOURCE: begin
               priority if (stat.src_ok) begin
                  state_ff <= ST_LOAD;
               end else if (sel_ff < stat.sel_max) begin
                  sel_ff <= sel_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_LOAD: begin
               step_ff  <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (step_ff == csds_pkg::DIV_CNT_W'(csds_pkg::DIV_CYCLES - 1)) begin
                  state_ff <= ST_COMPARE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_COMPARE: begin
               priority if (m_ff < stat.m_max) begin
                  m_ff     <= m_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end else if (n_ff < stat.n_max) begin
                  n_ff     <= n_ff + 1'b1;
                  m_ff     <= '0;
                  state_ff <= ST_LOAD;
               end else if (sel_ff < stat.sel_max) begin
                  sel_ff   <= sel_ff + 1'b1;
                  n_ff     <= '0;
                  m_ff     <= '0;
                  state_ff <= ST_SOURCE;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.init    = (state_ff == ST_IDLE) && start;
   assign cmd.load    = (state_ff == ST_LOAD);
   assign cmd.step    = (state_ff == ST_DIVIDE);
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.finish  = (state_ff == ST_FINISH);
   assign cmd.sel     = sel_ff;
   assign cmd.n       = n_ff;
   assign cmd.m       = m_ff;

endmodule

[design/csds_checker.sv]
// Port-level checker for the divider search core and its bind.
`include "clock_source_divider_search_core_defines.svh"

module csds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [csds_pkg::RATE_W-1:0]      req_target_rate,
   input logic                             rsp_valid,
   input logic [1:0]                       rsp_status,
   input logic [1:0]                       rsp_best_source,
   input logic [1:0]                       rsp_best_exponent,
   input logic [3:0]                       rsp_best_linear,
   input logic [csds_pkg::RATE_W-1:0]      rsp_achieved_rate,
   input logic [csds_pkg::RATE_W-1:0]      rsp_field_value,
   input logic [csds_pkg::RATE_W-1:0]      rsp_field_mask,
   input logic                             csr_write_enable,
   input logic [csds_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [csds_pkg::RATE_W-1:0]      csr_write_data
);

   // an accepted transaction keeps the core busy
   `CSDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")

   // the result strobe comes once the search is over
   `CSDS_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result while busy")

   // one strobe per transaction
   `CSDS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result held longer than a cycle")

   // leaving busy always delivers the result
   `CSDS_ASSERT_SAME(a_done_rsp, !$past(reset) && $fell(busy), rsp_valid,
                     "search ended without result")

   // failures carry no setting
   `CSDS_ASSERT_SAME(a_fail_zero, rsp_valid && (rsp_status != csds_pkg::STATUS_FOUND),
                     (rsp_achieved_rate == '0) && (rsp_field_mask == '0),
                     "failed result carries a setting")

endmodule

bind clock_source_divider_search_core csds_checker u_checker (.*);
